// ----- hw/rtl/crc16fc_pkg.sv -----
// Shared constants, status codes and the CRC-16 byte update for the frame checker.
package crc16fc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_TOP  = 16'h8000;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_CRC_BAD  = 2'd2;
    localparam logic [1:0] ST_ID_BAD   = 2'd3;

    localparam logic [1:0] SEEN_MAX = 2'd3;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_crc;

    // MSB-first CRC-16 update over one byte
    function automatic t_crc crc_feed(input t_crc crc, input t_byte b);
        t_crc c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != '0) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/crc16fc_if.sv -----
// Valid/ready channel interfaces for frame bytes and frame check results.
interface crc16fc_in_if;
    import crc16fc_pkg::*;
    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  last_byte;
    t_byte expected_id;

    modport source (output valid, output data_byte, output last_byte, output expected_id,
                    input ready);
    modport sink   (input valid, input data_byte, input last_byte, input expected_id,
                    output ready);
endinterface

interface crc16fc_out_if;
    import crc16fc_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] frame_status;
    t_crc       computed_crc;
    t_crc       received_crc;

    modport source (output valid, output frame_status, output computed_crc,
                    output received_crc, input ready);
    modport sink   (input valid, input frame_status, input computed_crc,
                    input received_crc, output ready);
endinterface

// ----- hw/rtl/crc16_frame_checker_core.sv -----
// Frame checker top level: CRC-16 and command id check over a received reply frame.
// One byte per cycle when the input stage is not stalled. A byte request is registered in
// the input stage and processed, once that stage advances, by an unrolled 8-bit CRC update
// on the byte leaving the two-byte window; on the byte marked last, the status lands in the
// result register. The input stage stalls only when it holds a last byte and the result
// register is still occupied. Status codes: 0 ok, 1 too short, 2 CRC mismatch (wins over
// id mismatch), 3 id mismatch.
module crc16_frame_checker_core
    import crc16fc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    crc16fc_in_if.sink    i_in,
    crc16fc_out_if.source o_out
);

    logic       r_in_valid;
    t_byte      r_in_byte;
    logic       r_in_last;
    t_byte      r_in_expect;

    t_crc       r_crc;
    t_byte      r_older;
    t_byte      r_newer;
    logic [1:0] r_seen;
    t_byte      r_id;

    logic       r_out_valid;
    logic [1:0] r_out_status;
    t_crc       r_out_computed;
    t_crc       r_out_received;

    logic       out_free;
    logic       stage_adv;
    logic       in_take;

    t_crc       n_crc;
    t_byte      n_id;
    logic [1:0] n_seen;
    logic [1:0] n_status;
    t_crc       n_computed;
    t_crc       n_received;

    assign out_free  = !r_out_valid || o_out.ready;
    assign stage_adv = r_in_valid && (!r_in_last || out_free);
    assign i_in.ready = !r_in_valid || stage_adv;
    assign in_take   = i_in.valid && i_in.ready;

    always_comb begin
        n_crc  = (r_seen >= 2'd2) ? crc_feed(r_crc, r_older) : r_crc;
        n_id   = (r_seen == 2'd1) ? r_in_byte : r_id;
        n_seen = (r_seen == SEEN_MAX) ? SEEN_MAX : r_seen + 2'd1;
        if (n_seen < 2'd2) begin
            n_status   = ST_SHORT;
            n_computed = '0;
            n_received = '0;
        end else begin
            n_computed = n_crc;
            n_received = {r_newer, r_in_byte};
            if (n_computed != n_received) begin
                n_status = ST_CRC_BAD;
            end else if (n_id != r_in_expect) begin
                n_status = ST_ID_BAD;
            end else begin
                n_status = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (in_take) begin
            r_in_byte   <= i_in.data_byte;
            r_in_last   <= i_in.last_byte;
            r_in_expect <= i_in.expected_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_older <= '0;
            r_newer <= '0;
            r_seen  <= '0;
            r_id    <= '0;
        end else if (stage_adv) begin
            if (r_in_last) begin
                r_crc   <= CRC_INIT;
                r_older <= '0;
                r_newer <= '0;
                r_seen  <= '0;
                r_id    <= '0;
            end else begin
                r_crc   <= n_crc;
                r_older <= r_newer;
                r_newer <= r_in_byte;
                r_seen  <= n_seen;
                r_id    <= n_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= stage_adv && r_in_last;
        end
        if (stage_adv && r_in_last) begin
            r_out_status   <= n_status;
            r_out_computed <= n_computed;
            r_out_received <= n_received;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_status = r_out_status;
    assign o_out.computed_crc = r_out_computed;
    assign o_out.received_crc = r_out_received;

    a_last_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_adv && r_in_last) |-> out_free)
        else $error("last byte advanced into an occupied result register");

    a_frame_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_adv && r_in_last) |=> (r_seen == 2'd0 && r_crc == CRC_INIT))
        else $error("frame state not cleared after last byte");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_SHORT) |->
            (r_out_computed == '0 && r_out_received == '0))
        else $error("too-short frame reported nonzero CRC fields");

    a_good_crc_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_OK || r_out_status == ST_ID_BAD)) |->
            (r_out_computed == r_out_received))
        else $error("CRC passed with differing computed and received values");

endmodule

// ----- tb/crc16_frame_checker_core_tb.sv -----
// Self-checking testbench for the CRC-16 frame checker core, with its own frame predictor.
module crc16_frame_checker_core_tb
    import crc16fc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_byte data_byte;
        logic  last_byte;
        t_byte expected_id;
        bit    hold;
    } t_frame_byte;

    typedef struct {
        logic [1:0] frame_status;
        t_crc       computed_crc;
        t_crc       received_crc;
    } t_frame_verdict;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam int QUIET_FROM  = 450;
    localparam int QUIET_TO    = 700;

    logic i_clk;
    logic i_rst_n;

    crc16fc_in_if  in_if();
    crc16fc_out_if out_if();

    crc16_frame_checker_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_frame_byte    byte_q[$];
    t_frame_verdict verdict_q[$];
    int             mismatch_cnt = 0;
    int             sent_cnt = 0;
    int             queued_cnt = 0;
    logic           byte_taken = 1'b0;

    // predictor state
    t_crc       run_crc = CRC_INIT;
    t_byte      win_old = '0;
    t_byte      win_new = '0;
    logic [1:0] seen_cnt = '0;
    t_byte      id_seen = '0;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic t_crc crc_shift_byte(input t_crc acc, input t_byte b);
        t_crc r;
        logic fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ b[k];
            r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic predict_byte(input t_byte b, input logic last, input t_byte want_id);
        t_frame_verdict v;
        if (seen_cnt >= 2'd2) begin
            run_crc = crc_shift_byte(run_crc, win_old);
        end
        if (seen_cnt == 2'd1) begin
            id_seen = b;
        end
        win_old = win_new;
        win_new = b;
        if (seen_cnt < SEEN_MAX) begin
            seen_cnt = seen_cnt + 2'd1;
        end
        if (last) begin
            if (seen_cnt < 2'd2) begin
                v.frame_status = ST_SHORT;
                v.computed_crc = '0;
                v.received_crc = '0;
            end else begin
                v.computed_crc = run_crc;
                v.received_crc = {win_old, win_new};
                if (v.computed_crc != v.received_crc) begin
                    v.frame_status = ST_CRC_BAD;
                end else if (id_seen != want_id) begin
                    v.frame_status = ST_ID_BAD;
                end else begin
                    v.frame_status = ST_OK;
                end
            end
            verdict_q.push_back(v);
            run_crc = CRC_INIT;
            win_old = '0;
            win_new = '0;
            seen_cnt = '0;
            id_seen = '0;
        end
    endtask

    // builds one frame; a good CRC is appended big-endian over all but the last two bytes
    task automatic queue_frame(input int len, input int fill, input bit crc_ok, input bit id_ok,
                               input bit pause);
        t_byte       body[$];
        t_crc        c;
        t_byte       want;
        t_frame_byte fb;
        body.delete();
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: body.push_back(8'h00);
                FILL_ONES: body.push_back(8'hFF);
                default:   body.push_back(t_byte'($urandom_range(255)));
            endcase
        end
        if (len >= 2) begin
            c = CRC_INIT;
            for (int i = 0; i < len - 2; i++) begin
                c = crc_shift_byte(c, body[i]);
            end
            if (crc_ok) begin
                body[len-2] = c[15:8];
                body[len-1] = c[7:0];
            end else if ({body[len-2], body[len-1]} == c) begin
                body[len-1] = body[len-1] ^ 8'h01;
            end
            want = id_ok ? body[1] : body[1] ^ t_byte'($urandom_range(1, 255));
        end else begin
            want = t_byte'($urandom_range(255));
        end
        for (int i = 0; i < len; i++) begin
            fb.data_byte   = body[i];
            fb.last_byte   = (i == len - 1);
            fb.expected_id = (i == len - 1) ? want : t_byte'($urandom_range(255));
            fb.hold        = pause && (i == 0);
            byte_q.push_back(fb);
        end
        queued_cnt += len;
    endtask

    // sender
    always @(negedge i_clk) begin
        t_frame_byte nxt;
        bit          go;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || byte_taken) begin
            go = 1'b0;
            if (byte_q.size() != 0) begin
                if (byte_q[0].hold && verdict_q.size() != 0) begin
                    go = 1'b0;
                end else begin
                    go = (sent_cnt >= QUIET_FROM && sent_cnt < QUIET_TO)
                         || ($urandom_range(99) >= 16);
                end
            end
            if (go) begin
                nxt = byte_q.pop_front();
                in_if.valid       <= 1'b1;
                in_if.data_byte   <= nxt.data_byte;
                in_if.last_byte   <= nxt.last_byte;
                in_if.expected_id <= nxt.expected_id;
                sent_cnt++;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= (sent_cnt >= QUIET_FROM && sent_cnt < QUIET_TO)
                            || ($urandom_range(99) >= 16);
        end
    end

    // accepted byte requests feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
            predict_byte(in_if.data_byte, in_if.last_byte, in_if.expected_id);
            byte_taken <= 1'b1;
        end else begin
            byte_taken <= 1'b0;
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_frame_verdict v;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (verdict_q.size() == 0) begin
                log_mismatch($sformatf("unexpected result status=%0d computed=%h received=%h",
                             out_if.frame_status, out_if.computed_crc, out_if.received_crc));
            end else begin
                v = verdict_q.pop_front();
                if (out_if.frame_status !== v.frame_status) begin
                    log_mismatch($sformatf("frame_status got %0d want %0d",
                                 out_if.frame_status, v.frame_status));
                end
                if (out_if.computed_crc !== v.computed_crc) begin
                    log_mismatch($sformatf("computed_crc got %h want %h",
                                 out_if.computed_crc, v.computed_crc));
                end
                if (out_if.received_crc !== v.received_crc) begin
                    log_mismatch($sformatf("received_crc got %h want %h",
                                 out_if.received_crc, v.received_crc));
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int len;
        int pick;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.data_byte   = '0;
        in_if.last_byte   = 1'b0;
        in_if.expected_id = '0;
        out_if.ready      = 1'b0;

        // directed: short frames, empty CRC span, all-zero / all-one content, each status
        queue_frame(1, FILL_ONES, 1'b1, 1'b1, 1'b0);
        queue_frame(1, FILL_ZERO, 1'b1, 1'b1, 1'b0);
        queue_frame(2, FILL_ONES, 1'b1, 1'b1, 1'b0);
        queue_frame(2, FILL_ZERO, 1'b0, 1'b1, 1'b0);
        queue_frame(4, FILL_ZERO, 1'b1, 1'b1, 1'b0);
        queue_frame(4, FILL_ONES, 1'b1, 1'b0, 1'b0);
        queue_frame(5, FILL_RANDOM, 1'b0, 1'b0, 1'b0);
        queue_frame(3, FILL_RANDOM, 1'b1, 1'b1, 1'b1);

        while (queued_cnt < 1150) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                len = 1;
            end else if (pick < 10) begin
                len = 2;
            end else if (pick < 80) begin
                len = $urandom_range(3, 12);
            end else if (pick < 95) begin
                len = $urandom_range(13, 40);
            end else begin
                len = $urandom_range(41, 80);
            end
            queue_frame(len, ($urandom_range(19) == 0) ? FILL_ZERO : FILL_RANDOM,
                        $urandom_range(99) < 75, $urandom_range(99) < 80,
                        $urandom_range(99) < 3);
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
